>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MKTX_ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition that must never be true outside reset
`define MKTX_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> sv/mktx_pkg.sv
// shared constants and types for the k-transaction max profit block
`timescale 1ns / 1ps

package mktx_pkg;

    localparam int PRICE_W       = 16;
    localparam int PROFIT_W      = 20;
    localparam int OUT_TDATA_W   = 24;
    localparam int CFG_W         = 5;
    localparam int MAX_TRANS_DEF = 16;

    localparam logic [CFG_W-1:0]    CFG_RESET  = 5'd2;
    localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

    // per-cycle control handed to every cell
    typedef struct packed {
        logic en;       // a price transfer happens this cycle
        logic clear;    // that transfer closes the sequence
    } step_t;

endpackage

>>> sv/mktx_cell.sv
// one transaction cell: best holding and best free cash for one transaction count
`timescale 1ns / 1ps

module mktx_cell #(
    parameter int FREE_W   = 21,
    parameter int HOLD_W   = 22,
    parameter int KW       = 5,
    parameter int CELL_IDX = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mktx_pkg::step_t               step,
    input  logic [mktx_pkg::PRICE_W-1:0]  price,
    input  logic [FREE_W-1:0]             free_prev,
    input  logic [KW-1:0]                 k_sel,
    input  logic [FREE_W-1:0]             pick_in,
    output logic [FREE_W-1:0]             pick_out,
    output logic [FREE_W-1:0]             free_out
);

    localparam int EXT_W = HOLD_W + 1;

    logic signed [HOLD_W-1:0] hold_reg, hold_next;
    logic        [FREE_W-1:0] free_reg, free_next;

    logic signed [EXT_W-1:0] hold_ext, free_ext, price_ext, prev_ext;
    logic signed [EXT_W-1:0] buy_val, sell_val, hold_cand, free_cand;

    // buy from the left neighbor's free cash, sell from own holding
    always_comb
    begin
        hold_ext  = {hold_reg[HOLD_W-1], hold_reg};
        free_ext  = {2'b00, free_reg};
        prev_ext  = {2'b00, free_prev};
        price_ext = {{(EXT_W-mktx_pkg::PRICE_W){1'b0}}, price};
        buy_val   = prev_ext - price_ext;
        sell_val  = hold_ext + price_ext;
        hold_cand = (buy_val > hold_ext) ? buy_val : hold_ext;
        free_cand = (sell_val > free_ext) ? sell_val : free_ext;
        hold_next = hold_cand[HOLD_W-1:0];
        free_next = free_cand[FREE_W-1:0];
    end

    // state update, back to unreachable / zero when the sequence ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= {1'b1, {(HOLD_W-1){1'b0}}};
            free_reg <= '0;
        end
        else if (step.clear)
        begin
            hold_reg <= {1'b1, {(HOLD_W-1){1'b0}}};
            free_reg <= '0;
        end
        else if (step.en)
        begin
            hold_reg <= hold_next;
            free_reg <= free_next;
        end
    end

    // the cell matching the limit drops its updated free cash onto the pick chain
    assign pick_out = pick_in | ((k_sel == KW'(CELL_IDX)) ? free_next : '0);
    assign free_out = free_reg;

endmodule

>>> sv/max_profit_k_transactions_top.sv
// top level of the k-transaction max profit block
// Accepts one price per clock cycle and updates MAX_TRANS transaction cells in
// parallel; per item each cell does a subtract, an add and two compares.
// The profit for a sequence appears on the master side in the cycle after its
// last price is transferred, and the cells are back at their reset values for
// the next sequence in that same cycle. The limit written on the config port
// saturates at MAX_TRANS; a limit of zero gives a profit of zero. Prices keep
// flowing while a result is offered, as long as the master side takes it; the
// input stalls only in cycles where a result is held and not yet taken.
`timescale 1ns / 1ps

module max_profit_k_transactions_top #(
    parameter int MAX_TRANS = mktx_pkg::MAX_TRANS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mktx_pkg::CFG_W-1:0]        cfg_data,     // max_transactions
    // price stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mktx_pkg::PRICE_W-1:0]      s_tdata,      // [15:0] price
    input  logic                              s_tlast,
    // profit stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mktx_pkg::OUT_TDATA_W-1:0]  m_tdata       // [19:0] profit, rest zero
);

    localparam int CNT_W  = $clog2(MAX_TRANS + 1);
    localparam int FREE_W = CNT_W + mktx_pkg::PRICE_W;
    localparam int HOLD_W = FREE_W + 1;
    localparam int KW     = (CNT_W > mktx_pkg::CFG_W) ? CNT_W : mktx_pkg::CFG_W;
    localparam int SAT_W  = (FREE_W > mktx_pkg::PROFIT_W) ? FREE_W : mktx_pkg::PROFIT_W + 1;

    logic [mktx_pkg::CFG_W-1:0]    k_reg;
    logic [KW-1:0]                 k_ext, k_eff;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [mktx_pkg::PROFIT_W-1:0] profit_reg, profit_next;
    logic                          in_xfer;
    mktx_pkg::step_t               step;
    logic [SAT_W-1:0]              pick_ext;

    logic [FREE_W-1:0] free_q [MAX_TRANS+1];
    logic [FREE_W-1:0] pick   [MAX_TRANS+1];

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= mktx_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
            k_reg <= cfg_data;
    end

    // limit saturated to the number of cells
    assign k_ext = KW'(k_reg);
    assign k_eff = (k_ext > KW'(MAX_TRANS)) ? KW'(MAX_TRANS) : k_ext;

    // input side stalls only while a result is held and not yet taken
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign in_xfer    = s_tvalid && s_tready;
    assign step.en    = in_xfer;
    assign step.clear = in_xfer && s_tlast;

    // chain of transaction cells
    assign free_q[0] = '0;
    assign pick[0]   = '0;

    for (genvar j = 0; j < MAX_TRANS; j++)
    begin : g_cell
        mktx_cell #(
            .FREE_W   (FREE_W),
            .HOLD_W   (HOLD_W),
            .KW       (KW),
            .CELL_IDX (j + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .price     (s_tdata),
            .free_prev (free_q[j]),
            .k_sel     (k_eff),
            .pick_in   (pick[j]),
            .pick_out  (pick[j+1]),
            .free_out  (free_q[j+1])
        );
    end

    // saturate the picked value to the output width
    assign pick_ext = SAT_W'(pick[MAX_TRANS]);

    always_comb
    begin
        if (pick_ext > SAT_W'(mktx_pkg::PROFIT_MAX))
            profit_next = mktx_pkg::PROFIT_MAX;
        else
            profit_next = pick_ext[mktx_pkg::PROFIT_W-1:0];
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (step.clear)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step.clear)
            profit_reg <= profit_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mktx_pkg::OUT_TDATA_W-mktx_pkg::PROFIT_W){1'b0}}, profit_reg};

endmodule

>>> sv/mktx_checker.sv
// port-level checker for the k-transaction max profit block, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mktx_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mktx_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // a stalled result stays offered and unchanged
    `MKTX_ASSERT_PROP(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)
    `MKTX_ASSERT_PROP(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata))

    // a closing price always yields a result in the next cycle
    `MKTX_ASSERT_PROP(a_last_result, s_tvalid && s_tready && s_tlast |=> m_tvalid)

    // input stalls only behind a held result
    `MKTX_ASSERT_PROP(a_stall_cause, !s_tready |-> m_tvalid && !m_tready)

    // padding above the profit field stays zero
    `MKTX_ASSERT_NEVER(a_pad_zero, m_tvalid && (m_tdata[23:mktx_pkg::PROFIT_W] != '0))

endmodule

bind max_profit_k_transactions_top mktx_checker u_mktx_checker (.*);
